### rtl/oaht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  // Table size, a power of two.
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // A set is refused once used_count reaches three quarters of the table.
  localparam int LOAD_MAX = (3 * CAPACITY) / 4;

  localparam int KEY_W = 32;
  localparam int VAL_W = 64;
  localparam int OP_W  = 2;

  localparam int IN_DATA_W  = 2 * KEY_W + VAL_W;
  localparam int OUT_DATA_W = VAL_W;
  localparam int OUT_USER_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_DEL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_PROBE = 2'd1,
    S_DONE  = 2'd2
  } oaht_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic commit;
  } oaht_cmd_t;

  typedef struct packed {
    logic probe_done;
    logic out_free;
  } oaht_sts_t;

endpackage
`default_nettype wire

### rtl/oaht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_ctrl
// Request sequencer: accept a word, walk the probe, commit the result.
// ----------------------------------------------------------------------------
module oaht_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire oaht_pkg::oaht_sts_t sts,
  output oaht_pkg::oaht_cmd_t     cmd
);

  oaht_pkg::oaht_state_t state_r;
  oaht_pkg::oaht_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oaht_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      oaht_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = oaht_pkg::S_PROBE;
        end
      end
      oaht_pkg::S_PROBE: begin
        if (sts.probe_done) begin
          cmd.finish = 1'b1;
          state_nxt  = oaht_pkg::S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      oaht_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = oaht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = oaht_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/oaht_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_dp
// Slot memories, probe registers, result decision and output register.
// ----------------------------------------------------------------------------
module oaht_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [oaht_pkg::OP_W-1:0]           in_tuser,
  input  wire logic [oaht_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire oaht_pkg::oaht_cmd_t                 cmd,
  output oaht_pkg::oaht_sts_t                      sts,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [oaht_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic [oaht_pkg::OUT_USER_W-1:0]          out_tuser
);

  localparam int IDX_W = oaht_pkg::IDX_W;
  localparam int CNT_W = oaht_pkg::CNT_W;
  localparam int KEY_W = oaht_pkg::KEY_W;
  localparam int VAL_W = oaht_pkg::VAL_W;

  // slot storage
  oaht_pkg::slot_st_t     st_mem  [oaht_pkg::CAPACITY];
  logic [KEY_W-1:0]       key_mem [oaht_pkg::CAPACITY];
  logic [VAL_W-1:0]       val_mem [oaht_pkg::CAPACITY];
  logic [oaht_pkg::CAPACITY-1:0] vld_r;

  logic [IDX_W-1:0]       rd_addr;
  oaht_pkg::slot_st_t     rd_st_r;
  logic                   rd_vld_r;
  logic [KEY_W-1:0]       rd_key_r;
  logic [VAL_W-1:0]       rd_val_r;

  // request and probe registers
  oaht_pkg::op_t          op_r;
  logic [KEY_W-1:0]       key_r;
  logic [VAL_W-1:0]       wval_r;
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       idx_nxt;
  logic [IDX_W-1:0]       n_r;
  logic [IDX_W-1:0]       tomb_r;
  logic                   tomb_vld_r;
  logic [CNT_W-1:0]       used_r;

  // pending result and write
  logic                   res_hit_r;
  logic                   res_full_r;
  logic [VAL_W-1:0]       res_val_r;
  logic                   wr_st_en_r;
  logic                   wr_kv_en_r;
  oaht_pkg::slot_st_t     wr_st_r;
  logic [IDX_W-1:0]       wr_addr_r;
  logic                   wr_inc_r;

  logic                   out_tvalid_r;
  logic [VAL_W-1:0]       out_val_r;
  logic                   out_hit_r;
  logic                   out_full_r;

  // decision
  oaht_pkg::slot_st_t     cur_st;
  logic                   found;
  logic                   at_empty;
  logic                   exhausted;
  logic                   lim_full;
  logic                   early;
  logic                   slot_ok;
  logic                   slot_fresh;
  logic [IDX_W-1:0]       slot_addr;
  logic                   d_hit;
  logic                   d_full;
  logic [VAL_W-1:0]       d_val;
  logic                   d_st_en;
  logic                   d_kv_en;
  oaht_pkg::slot_st_t     d_st;
  logic [IDX_W-1:0]       d_addr;
  logic                   d_inc;

  assign idx_nxt = idx_r + 1'b1;

  always_comb begin
    if (cmd.load) begin
      rd_addr = in_tdata[KEY_W +: IDX_W];
    end else if (cmd.step) begin
      rd_addr = idx_nxt;
    end else begin
      rd_addr = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_st_en_r) begin
      st_mem[wr_addr_r] <= wr_st_r;
    end
    if (cmd.commit && wr_kv_en_r) begin
      key_mem[wr_addr_r] <= key_r;
      val_mem[wr_addr_r] <= wval_r;
    end
    rd_st_r  <= st_mem[rd_addr];
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.commit && wr_st_en_r) begin
        vld_r[wr_addr_r] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign cur_st    = rd_vld_r ? rd_st_r : oaht_pkg::ST_EMPTY;
  assign found     = (cur_st == oaht_pkg::ST_USED) && (rd_key_r == key_r);
  assign at_empty  = (cur_st == oaht_pkg::ST_EMPTY);
  assign exhausted = (n_r == {IDX_W{1'b1}});
  assign lim_full  = (used_r >= CNT_W'(oaht_pkg::LOAD_MAX));

  always_comb begin
    case (op_r) inside
      oaht_pkg::OP_GET,
      oaht_pkg::OP_DEL: early = (used_r == '0);
      oaht_pkg::OP_SET: early = lim_full;
      default:          early = 1'b1;
    endcase
  end

  always_comb begin
    slot_addr  = idx_r;
    slot_ok    = 1'b1;
    slot_fresh = 1'b0;
    if (!found) begin
      if (at_empty) begin
        slot_addr  = tomb_vld_r ? tomb_r : idx_r;
        slot_fresh = !tomb_vld_r;
      end else begin
        slot_addr = tomb_vld_r ? tomb_r : idx_r;
        slot_ok   = tomb_vld_r || (cur_st == oaht_pkg::ST_TOMB);
      end
    end
  end

  always_comb begin
    d_hit   = 1'b0;
    d_full  = 1'b0;
    d_val   = '0;
    d_st_en = 1'b0;
    d_kv_en = 1'b0;
    d_st    = oaht_pkg::ST_USED;
    d_addr  = slot_addr;
    d_inc   = 1'b0;
    if (early) begin
      d_full = (op_r == oaht_pkg::OP_SET);
    end else begin
      case (op_r)
        oaht_pkg::OP_GET: begin
          d_hit = found;
          d_val = found ? rd_val_r : '0;
        end
        oaht_pkg::OP_SET: begin
          if (found) begin
            d_kv_en = 1'b1;
          end else if (slot_ok) begin
            d_hit   = 1'b1;
            d_st_en = 1'b1;
            d_kv_en = 1'b1;
            d_inc   = slot_fresh;
          end else begin
            d_full = 1'b1;
          end
        end
        oaht_pkg::OP_DEL: begin
          d_hit   = found;
          d_st_en = found;
          d_st    = oaht_pkg::ST_TOMB;
        end
        default: begin
          d_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= oaht_pkg::op_t'(in_tuser);
      key_r  <= in_tdata[KEY_W-1:0];
      wval_r <= in_tdata[2*KEY_W +: VAL_W];
      idx_r  <= in_tdata[KEY_W +: IDX_W];
    end else if (cmd.step) begin
      idx_r <= idx_nxt;
    end
    if (cmd.step && (cur_st == oaht_pkg::ST_TOMB) && !tomb_vld_r) begin
      tomb_r <= idx_r;
    end
    if (cmd.finish) begin
      res_hit_r  <= d_hit;
      res_full_r <= d_full;
      res_val_r  <= d_val;
      wr_st_r    <= d_st;
      wr_addr_r  <= d_addr;
    end
    if (cmd.commit) begin
      out_val_r  <= res_val_r;
      out_hit_r  <= res_hit_r;
      out_full_r <= res_full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r          <= '0;
      tomb_vld_r   <= 1'b0;
      used_r       <= '0;
      wr_st_en_r   <= 1'b0;
      wr_kv_en_r   <= 1'b0;
      wr_inc_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        n_r        <= '0;
        tomb_vld_r <= 1'b0;
      end else if (cmd.step) begin
        n_r <= n_r + 1'b1;
        if (cur_st == oaht_pkg::ST_TOMB) begin
          tomb_vld_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        wr_st_en_r <= d_st_en;
        wr_kv_en_r <= d_kv_en;
        wr_inc_r   <= d_inc;
      end
      if (cmd.commit && wr_inc_r) begin
        used_r <= used_r + 1'b1;
      end
      if (cmd.commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign sts.probe_done = early || found || at_empty || exhausted;
  assign sts.out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = {out_full_r, out_hit_r};

endmodule
`default_nettype wire

### rtl/open_addressing_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Fixed-size key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// One request is handled at a time. A refused set, an unknown operation or a
// lookup in an empty table ends the probe at its first slot. The next word is
// taken in the cycle after the result is committed to the output register. The
// probe reads one slot per cycle through the single read port of the slot
// memories. The result waits in an output register, and a stalled result holds
// back only the commit of the following request.
// CAPACITY must be a power of two; there is no clearing pass after reset.
module open_addressing_hash_table (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [1:0] operation
  input  wire logic [oaht_pkg::OP_W-1:0]           in_tuser,
  // [31:0] key, [63:32] key_hash, [127:64] write_value
  input  wire logic [oaht_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [63:0] read_value
  output logic [oaht_pkg::OUT_DATA_W-1:0]          out_tdata,
  // [0] hit, [1] table_full
  output logic [oaht_pkg::OUT_USER_W-1:0]          out_tuser
);

  oaht_pkg::oaht_cmd_t cmd;
  oaht_pkg::oaht_sts_t sts;

  oaht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  oaht_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_hit_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("hit and table_full both set");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new word taken during a request");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("committed result not presented");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid || out_tready))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

### bench/open_addressing_hash_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_test
// Self-checking bench for the linear-probing hash table. A directed table
// walks the empty-table misses, wrap-around, overwrite, delete, tombstone
// reuse and the unknown operation. Random get/set/delete traffic follows on a
// small pool of keys with clustered hashes, then a fill phase drives the table
// to its load limit. Results are checked against the directed table or a local
// shadow, with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_test;
  import oaht_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int RANDOM_REQUESTS = 1600;
  localparam int QUIET_FROM      = 400;
  localparam int QUIET_TO        = 600;
  localparam int FILL_FROM       = 1000;
  localparam int FILL_TO         = 1300;
  localparam int STALL_AT        = 150;
  localparam int STALL_CYCLES    = 400;
  localparam int DRAIN_CYCLES    = 2 * CAPACITY + 20;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int POOL_SIZE       = 64;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] key_hash;
    logic [VAL_W-1:0] write_value;
  } request_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             table_full;
  } outcome_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    outcome_t want;
  } plan_row_t;

  localparam outcome_t MISS = '{1'b0, 64'h0, 1'b0};
  localparam outcome_t HIT0 = '{1'b1, 64'h0, 1'b0};
  localparam int PLAN_ROWS = 23;

  plan_row_t plan [PLAN_ROWS] = '{
    '{'{OP_GET, 32'h0000_0001, 32'h0000_0010, 64'h0}, 1'b1, MISS},
    '{'{OP_DEL, 32'h0000_0001, 32'h0000_0010, 64'h0}, 1'b1, MISS},
    '{'{OP_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, MISS},
    '{'{OP_SET, 32'h0000_0000, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, HIT0},
    '{'{OP_SET, 32'hFFFF_FFFF, 32'h0000_00FF, 64'h0}, 1'b1, HIT0},
    '{'{OP_GET, 32'hFFFF_FFFF, 32'h0000_00FF, 64'h0}, 1'b1, HIT0},
    '{'{OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 64'h0}, 1'b1,
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}},
    '{'{OP_SET, 32'h0000_0000, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF}, 1'b1, MISS},
    '{'{OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 64'h0}, 1'b1,
      '{1'b1, 64'h0123_4567_89AB_CDEF, 1'b0}},
    '{'{OP_DEL, 32'h0000_0000, 32'hFFFF_FFFF, 64'h0}, 1'b1, HIT0},
    '{'{OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 64'h0}, 1'b1, MISS},
    '{'{OP_GET, 32'hFFFF_FFFF, 32'h0000_00FF, 64'h0}, 1'b0, MISS},
    '{'{OP_SET, 32'h5A5A_5A5A, 32'hAAAA_AAFF, 64'hA5A5_A5A5_A5A5_A5A5}, 1'b0, MISS},
    '{'{OP_GET, 32'h5A5A_5A5A, 32'hAAAA_AAFF, 64'h0}, 1'b0, MISS},
    '{'{OP_DEL, 32'h5A5A_5A5A, 32'hAAAA_AAFF, 64'h0}, 1'b0, MISS},
    '{'{OP_DEL, 32'h5A5A_5A5A, 32'hAAAA_AAFF, 64'h0}, 1'b0, MISS},
    '{'{OP_UNKNOWN, 32'h1234_5678, 32'h8000_0000, 64'h5555_5555_5555_5555}, 1'b0, MISS},
    '{'{OP_SET, 32'h8000_0000, 32'h8000_0000, 64'h8000_0000_0000_0000}, 1'b0, MISS},
    '{'{OP_GET, 32'h8000_0000, 32'h8000_0000, 64'h0}, 1'b0, MISS},
    '{'{OP_GET, 32'h1234_5678, 32'h0000_0001, 64'h0}, 1'b0, MISS},
    '{'{OP_DEL, 32'hFFFF_FFFF, 32'h0000_00FF, 64'h0}, 1'b0, MISS},
    '{'{OP_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF}, 1'b0, MISS},
    '{'{OP_GET, 32'hFFFF_FFFF, 32'h0000_00FF, 64'h0}, 1'b0, MISS}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OP_W-1:0]       in_tuser = '0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  open_addressing_hash_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // shadow of the table
  slot_st_t         shadow_status [CAPACITY];
  logic [KEY_W-1:0] shadow_key    [CAPACITY];
  logic [VAL_W-1:0] shadow_value  [CAPACITY];
  int               shadow_used;

  outcome_t         pending_results [$];
  logic [KEY_W-1:0] pool_key  [POOL_SIZE];
  logic [KEY_W-1:0] pool_hash [POOL_SIZE];

  int  requests_sent;
  int  mismatches;
  int  cycles;
  int  get_hits, inserts, removals, refusals;
  bit  quiet_window;
  int  stall_left;
  bit  stall_done;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Probe from hash: matching slot, else first tombstone, else first empty.
  function automatic int probe_slot(input logic [KEY_W-1:0] key,
                                    input logic [KEY_W-1:0] key_hash, output bit found);
    int idx;
    int tomb;
    idx = int'(key_hash[IDX_W-1:0]);
    tomb = -1;
    found = 1'b0;
    for (int n = 0; n < CAPACITY; n++) begin
      if (shadow_status[idx] == ST_EMPTY) return (tomb >= 0) ? tomb : idx;
      if (shadow_status[idx] == ST_TOMB) begin
        if (tomb < 0) tomb = idx;
      end else if (shadow_key[idx] == key) begin
        found = 1'b1;
        return idx;
      end
      idx = (idx + 1) % CAPACITY;
    end
    return tomb;
  endfunction

  function automatic outcome_t apply_request(input request_t rq);
    outcome_t res;
    bit       found;
    int       idx;
    res = '0;
    case (rq.op)
      OP_GET: begin
        if (shadow_used != 0) begin
          idx = probe_slot(rq.key, rq.key_hash, found);
          if (found && idx >= 0) begin
            res.hit = 1'b1;
            res.read_value = shadow_value[idx];
          end
        end
      end
      OP_SET: begin
        if (4 * (shadow_used + 1) > 3 * CAPACITY) begin
          res.table_full = 1'b1;
        end else begin
          idx = probe_slot(rq.key, rq.key_hash, found);
          if (idx < 0) begin
            res.table_full = 1'b1;
          end else if (found) begin
            shadow_value[idx] = rq.write_value;
          end else begin
            if (shadow_status[idx] == ST_EMPTY) shadow_used++;
            shadow_status[idx] = ST_USED;
            shadow_key[idx] = rq.key;
            shadow_value[idx] = rq.write_value;
            res.hit = 1'b1;
          end
        end
      end
      OP_DEL: begin
        if (shadow_used != 0) begin
          idx = probe_slot(rq.key, rq.key_hash, found);
          if (found && idx >= 0) begin
            shadow_status[idx] = ST_TOMB;
            res.hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    return {$urandom, $urandom};
  endfunction

  function automatic request_t random_request(input int n);
    request_t rq;
    int       pick;
    int       roll;
    roll = $urandom_range(99);
    rq.write_value = random_value();
    if (n >= FILL_FROM && n < FILL_TO && roll < 80) begin
      // fresh keys to push the table to its load limit
      rq.op = OP_SET;
      rq.key = $urandom;
      rq.key_hash = $urandom;
    end else if ((n < FILL_FROM && roll < 10) || (n >= FILL_TO && roll < 15)) begin
      rq.op = OP_W'($urandom_range(3));
      rq.key = $urandom;
      rq.key_hash = $urandom;
    end else begin
      pick = (n < FILL_FROM) ? $urandom_range(23) : $urandom_range(POOL_SIZE - 1);
      rq.key = pool_key[pick];
      rq.key_hash = pool_hash[pick];
      roll = $urandom_range(99);
      if (roll < 35) rq.op = OP_GET;
      else if (roll < 75) rq.op = OP_SET;
      else if (roll < 97) rq.op = OP_DEL;
      else rq.op = OP_UNKNOWN;
    end
    return rq;
  endfunction

  // Offer one word, hold it until taken, then record what it must return.
  task automatic offer_request(input request_t rq, input logic typed, input outcome_t want);
    outcome_t predicted;
    while (!quiet_window && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= rq.op;
    in_tdata <= {rq.write_value, rq.key_hash, rq.key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_request(rq);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
    if (predicted.table_full) refusals++;
    else if (predicted.hit && rq.op == OP_GET) get_hits++;
    else if (predicted.hit && rq.op == OP_SET) inserts++;
    else if (predicted.hit && rq.op == OP_DEL) removals++;
  endtask

  // Output side: random idling, one long hold once traffic is flowing.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && requests_sent >= STALL_AT) begin
      out_tready <= 1'b0;
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else begin
      out_tready <= !rst_n ? 1'b0 : (quiet_window || $urandom_range(99) >= 19);
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no request pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_tuser[0]);
          mismatches++;
        end
        if (out_tdata !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_tdata);
          mismatches++;
        end
        if (out_tuser[1] !== want.table_full) begin
          $error("table_full: expected %0d, got %0d", want.table_full, out_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [7:0] cluster_base [4];
    logic [7:0] low;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_status[i] = ST_EMPTY;
      shadow_key[i] = '0;
      shadow_value[i] = '0;
    end
    shadow_used = 0;
    // clustered hashes make long probe chains; the cluster near the top slot forces wrap-around
    cluster_base[0] = 8'd250;
    cluster_base[1] = 8'd60;
    cluster_base[2] = 8'd128;
    cluster_base[3] = 8'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) begin
      low = cluster_base[i % 4] + 8'($urandom_range(5));
      pool_key[i] = $urandom;
      pool_hash[i] = ($urandom & 32'hFFFF_FF00) | {24'h0, low};
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++)
      offer_request(plan[r].req, plan[r].typed, plan[r].want);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      quiet_window = (n >= QUIET_FROM && n < QUIET_TO);
      offer_request(random_request(n), 1'b0, MISS);
    end
    quiet_window = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d requests: %0d get hits, %0d inserts, %0d deletes, %0d refused sets",
             requests_sent, get_hits, inserts, removals, refusals);
    $display("table ended with %0d of %0d slots used or tombstoned", shadow_used, CAPACITY);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
